// ----- src/mlrq_pkg.sv -----
// shared constants, types and codes of the multilevel ready-queue scheduler
package mlrq_pkg;

  localparam int LEVELS     = 8;
  localparam int TASK_SLOTS = 256;

  localparam int SLOT_W  = 8;
  localparam int PRIO_W  = 4;
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int IDX_W   = $clog2(TASK_SLOTS);
  localparam int CNT_W   = $clog2(TASK_SLOTS + 1);
  localparam int DEPTH   = LEVELS * TASK_SLOTS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {
    FUNC_ENQUEUE = 1'b0,
    FUNC_PICK    = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PRIO = 2'd1,
    ST_FULL     = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  // command to the queue memory
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] wdata;
  } ram_cmd_t;

  // per-request outcome passed down the pipeline
  typedef struct packed {
    status_e status;
    logic    hit;
  } stage_res_t;

endpackage

// ----- src/mlrq_ifs.sv -----
// request and result channel interfaces

interface mlrq_req_if;
  import mlrq_pkg::*;
  logic              valid;
  logic              ready;
  func_e             func;
  logic [SLOT_W-1:0] task_slot;
  logic [PRIO_W-1:0] priority_req;

  modport source (output valid, func, task_slot, priority_req, input ready);
  modport sink   (input valid, func, task_slot, priority_req, output ready);
endinterface

interface mlrq_res_if;
  import mlrq_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] picked_slot;
  status_e           status;

  modport source (output valid, picked_slot, status, input ready);
  modport sink   (input valid, picked_slot, status, output ready);
endinterface

// ----- src/mlrq_ram.sv -----
// generic single-port ram with registered read
module mlrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/mlrq_sched.sv -----
// per-level queue pointers, counts and the enqueue / pick decision
module mlrq_sched (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  mlrq_pkg::func_e           func_i,
  input  logic [mlrq_pkg::SLOT_W-1:0] task_slot_i,
  input  logic [mlrq_pkg::PRIO_W-1:0] priority_req_i,
  output mlrq_pkg::ram_cmd_t        ram_cmd_o,
  output mlrq_pkg::stage_res_t      result_o
);
  import mlrq_pkg::*;

  logic [IDX_W-1:0] head_q   [LEVELS];
  logic [IDX_W-1:0] head_d   [LEVELS];
  logic [IDX_W-1:0] tail_q   [LEVELS];
  logic [IDX_W-1:0] tail_d   [LEVELS];
  logic [CNT_W-1:0] count_q  [LEVELS];
  logic [CNT_W-1:0] count_d  [LEVELS];
  logic [CNT_W-1:0] served_q [LEVELS];
  logic [CNT_W-1:0] served_d [LEVELS];

  logic [LEVELS-1:0] elig1, elig2;
  logic [LVL_W-1:0]  sel1, sel2, sel, lvl;
  logic              any1, any2, prio_bad;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    if (idx == IDX_W'(TASK_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = idx + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [LVL_W-1:0] l,
                                                  input logic [IDX_W-1:0] idx);
    return ADDR_W'(l) * ADDR_W'(TASK_SLOTS) + ADDR_W'(idx);
  endfunction

  // first level with work left in this round, and first non-empty level
  always_comb begin
    sel1 = '0;
    sel2 = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      elig1[l] = served_q[l] < count_q[l];
      elig2[l] = count_q[l] != '0;
      if (elig1[l]) begin
        sel1 = LVL_W'(l);
      end
      if (elig2[l]) begin
        sel2 = LVL_W'(l);
      end
    end
    any1 = |elig1;
    any2 = |elig2;
  end

  assign prio_bad = {1'b0, priority_req_i} >= (PRIO_W + 1)'(LEVELS);
  assign lvl      = LVL_W'(priority_req_i);
  assign sel      = any1 ? sel1 : sel2;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    served_d = served_q;
    ram_cmd_o        = '0;
    result_o.status  = ST_OK;
    result_o.hit     = 1'b0;

    case (func_i)
      FUNC_ENQUEUE: begin
        ram_cmd_o.addr  = store_addr(lvl, tail_q[lvl]);
        ram_cmd_o.wdata = task_slot_i;
        if (prio_bad) begin
          result_o.status = ST_BAD_PRIO;
        end else if (count_q[lvl] == CNT_W'(TASK_SLOTS)) begin
          result_o.status = ST_FULL;
        end else if (accept_i) begin
          ram_cmd_o.we  = 1'b1;
          tail_d[lvl]   = wrap_inc(tail_q[lvl]);
          count_d[lvl]  = count_q[lvl] + 1'b1;
        end
      end
      FUNC_PICK: begin
        ram_cmd_o.addr = store_addr(sel, head_q[sel]);
        result_o.hit   = any1 || any2;
        if (!(any1 || any2)) begin
          result_o.status = ST_NONE;
        end
        if (accept_i) begin
          ram_cmd_o.re = any1 || any2;
          // levels passed over lose their round; a second pass clears them all
          for (int l = 0; l < LEVELS; l++) begin
            if (!any1 || (LVL_W'(l) < sel1)) begin
              served_d[l] = '0;
            end
          end
          if (any1 || any2) begin
            served_d[sel] = any1 ? served_q[sel] + 1'b1 : CNT_W'(1);
            count_d[sel]  = count_q[sel] - 1'b1;
            head_d[sel]   = wrap_inc(head_q[sel]);
          end
        end
      end
      default: begin
        result_o.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l]   <= '0;
        tail_q[l]   <= '0;
        count_q[l]  <= '0;
        served_q[l] <= '0;
      end
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      served_q <= served_d;
    end
  end

endmodule

// ----- src/multilevel_ready_queue_scheduler_core.sv -----
// top level of the multilevel ready-queue scheduler
// One FIFO of task slot numbers per priority level (level 0 highest), held
// in a single queue memory of LEVELS*TASK_SLOTS bytes. An enqueue request
// appends a slot to its level's FIFO; it reports status 1 for a priority at
// or above LEVELS and status 2 for a full level. A pick request serves the
// highest level whose served count is below its current fill, pops its head
// and bumps the count; levels passed over have their counts cleared, and if
// no level qualifies a second pass serves the first non-empty level. With
// nothing queued the pick reports status 3. Every request yields exactly one
// result; picked_slot is zero except on a successful pick. A new request is
// accepted every cycle while results are being taken; each result passes
// stage 1, where the registered read of the queue memory completes, and then
// the result register. The queue memory needs no clearing after reset.
module multilevel_ready_queue_scheduler_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  mlrq_req_if.sink   req,
  mlrq_res_if.source res
);
  import mlrq_pkg::*;

  ram_cmd_t          ram_cmd;
  stage_res_t        sched_res;
  logic [SLOT_W-1:0] ram_rdata;

  logic              accept;
  logic              advance;

  // stage 1: decision taken, memory read in flight
  logic              s1_valid_q;
  stage_res_t        s1_res_q;

  // result register
  logic              out_valid_q;
  logic [SLOT_W-1:0] out_slot_q;
  status_e           out_status_q;

  // result register free or being emptied this cycle
  assign advance   = !out_valid_q || res.ready;
  assign req.ready = !s1_valid_q || advance;
  assign accept    = req.valid && req.ready;

  mlrq_sched u_sched (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .func_i         (req.func),
    .task_slot_i    (req.task_slot),
    .priority_req_i (req.priority_req),
    .ram_cmd_o      (ram_cmd),
    .result_o       (sched_res)
  );

  // queue memory; read data holds while stage 1 is stalled
  mlrq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_cmd.we),
    .re_i    (ram_cmd.re),
    .addr_i  (ram_cmd.addr),
    .wdata_i (ram_cmd.wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= sched_res;
    end
    if (advance && s1_valid_q) begin
      out_status_q <= s1_res_q.status;
      out_slot_q   <= s1_res_q.hit ? ram_rdata : '0;
    end
  end

  assign res.valid       = out_valid_q;
  assign res.picked_slot = out_slot_q;
  assign res.status      = out_status_q;

endmodule

// ----- dv/multilevel_ready_queue_scheduler_core_test.sv -----
// self-checking testbench for the multilevel ready-queue scheduler core
`timescale 1ns / 100ps

module multilevel_ready_queue_scheduler_core_test;
  import mlrq_pkg::*;

  // one scheduler answer as it leaves the result channel
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_e           status;
  } sched_result_t;

  // one row of the directed table; answers typed in only where obvious
  typedef struct {
    func_e             func;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] prio;
    bit                typed;
    logic [SLOT_W-1:0] exp_slot;
    status_e           exp_status;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_ITEMS  = 700;
  localparam int PRIO_MAX      = (1 << PRIO_W) - 1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mlrq_req_if req_ch ();
  mlrq_res_if res_ch ();

  multilevel_ready_queue_scheduler_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .res    (res_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the scheduler state, advanced once per accepted request
  logic [SLOT_W-1:0] lvl_store  [LEVELS][TASK_SLOTS];
  int unsigned       lvl_head   [LEVELS];
  int unsigned       lvl_tail   [LEVELS];
  int unsigned       lvl_fill   [LEVELS];
  int unsigned       lvl_served [LEVELS];

  sched_result_t expected_results [$];
  bit            run_failed;
  int unsigned   burst_left;

  // directed part: empty pick after reset, priority limits, slot extremes,
  // two-pass service order across levels, pick fields being ignored
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{FUNC_PICK,    8'h00, 4'h0, 1'b1, 8'h00, ST_NONE},      // nothing queued yet
    '{FUNC_ENQUEUE, 8'h5A, 4'hF, 1'b1, 8'h00, ST_BAD_PRIO},  // top priority code
    '{FUNC_ENQUEUE, 8'hA5, 4'h8, 1'b1, 8'h00, ST_BAD_PRIO},  // first level past the end
    '{FUNC_ENQUEUE, 8'hFF, 4'h0, 1'b1, 8'h00, ST_OK},
    '{FUNC_ENQUEUE, 8'h00, 4'h7, 1'b1, 8'h00, ST_OK},        // lowest level
    '{FUNC_ENQUEUE, 8'h81, 4'h0, 1'b1, 8'h00, ST_OK},
    '{FUNC_ENQUEUE, 8'h42, 4'h3, 1'b1, 8'h00, ST_OK},
    '{FUNC_ENQUEUE, 8'h7E, 4'h0, 1'b1, 8'h00, ST_OK},
    '{FUNC_PICK,    8'h00, 4'h0, 1'b0, 8'h00, ST_OK},
    '{FUNC_PICK,    8'h00, 4'h0, 1'b0, 8'h00, ST_OK},
    '{FUNC_PICK,    8'h00, 4'h0, 1'b0, 8'h00, ST_OK},
    '{FUNC_PICK,    8'h00, 4'h0, 1'b0, 8'h00, ST_OK},
    '{FUNC_PICK,    8'h00, 4'h0, 1'b0, 8'h00, ST_OK},
    '{FUNC_PICK,    8'h00, 4'h0, 1'b0, 8'h00, ST_OK},
    '{FUNC_PICK,    8'h00, 4'h0, 1'b0, 8'h00, ST_OK},        // drained by now
    '{FUNC_ENQUEUE, 8'h11, 4'h5, 1'b1, 8'h00, ST_OK},
    '{FUNC_ENQUEUE, 8'h22, 4'h5, 1'b1, 8'h00, ST_OK},
    '{FUNC_PICK,    8'hFF, 4'hF, 1'b0, 8'h00, ST_OK},        // slot and priority ignored
    '{FUNC_PICK,    8'hFF, 4'hF, 1'b0, 8'h00, ST_OK},
    '{FUNC_PICK,    8'h00, 4'h0, 1'b0, 8'h00, ST_OK},
    '{FUNC_ENQUEUE, 8'hC3, 4'h9, 1'b1, 8'h00, ST_BAD_PRIO},
    '{FUNC_PICK,    8'h00, 4'h0, 1'b0, 8'h00, ST_OK}
  };

  // scheduler prediction: enqueue to a level FIFO, or a two-pass pick in
  // which a passed-over level has its served count cleared
  function automatic sched_result_t schedule_next(input func_e             op,
                                                  input logic [SLOT_W-1:0] slot,
                                                  input logic [PRIO_W-1:0] prio);
    sched_result_t outcome;
    int unsigned   lvl;
    outcome.slot   = '0;
    outcome.status = ST_NONE;
    if (op == FUNC_ENQUEUE) begin
      lvl = 32'(prio);
      if (lvl >= LEVELS) begin
        outcome.status = ST_BAD_PRIO;
      end else if (lvl_fill[lvl] >= TASK_SLOTS) begin
        outcome.status = ST_FULL;
      end else begin
        lvl_store[lvl][lvl_tail[lvl]] = slot;
        lvl_tail[lvl] = (lvl_tail[lvl] + 1) % TASK_SLOTS;
        lvl_fill[lvl]++;
        outcome.status = ST_OK;
      end
    end else begin
      for (int pass = 0; pass < 2 && outcome.status == ST_NONE; pass++) begin
        for (int l = 0; l < LEVELS && outcome.status == ST_NONE; l++) begin
          if (lvl_served[l] < lvl_fill[l]) begin
            outcome.slot   = lvl_store[l][lvl_head[l]];
            outcome.status = ST_OK;
            lvl_head[l]    = (lvl_head[l] + 1) % TASK_SLOTS;
            lvl_fill[l]--;
            lvl_served[l]++;
          end else begin
            lvl_served[l] = 0;
          end
        end
      end
    end
    return outcome;
  endfunction

  // offer one request in bursts with random gaps; once it is taken the
  // expected answer is queued, typed in or predicted
  task automatic send_request(input func_e             op,
                              input logic [SLOT_W-1:0] slot,
                              input logic [PRIO_W-1:0] prio,
                              input bit                typed,
                              input sched_result_t     typed_res);
    sched_result_t predicted;
    int unsigned   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_ch.valid        <= 1'b1;
    req_ch.func         <= op;
    req_ch.task_slot    <= slot;
    req_ch.priority_req <= prio;
    do @(posedge clk_i); while (!req_ch.ready);
    predicted = schedule_next(op, slot, prio);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  // random enqueue: mostly valid levels, now and then one out of range
  task automatic send_random_enqueue();
    logic [PRIO_W-1:0] prio;
    if ($urandom_range(0, 9) == 0) begin
      prio = PRIO_W'($urandom_range(LEVELS, PRIO_MAX));
    end else begin
      prio = PRIO_W'($urandom_range(0, LEVELS - 1));
    end
    send_request(FUNC_ENQUEUE, SLOT_W'($urandom_range(0, 255)), prio, 1'b0, '0);
  endtask

  task automatic send_random_pick();
    send_request(FUNC_PICK, SLOT_W'($urandom_range(0, 255)),
                 PRIO_W'($urandom_range(0, PRIO_MAX)), 1'b0, '0);
  endtask

  // main sequence: reset, directed table, random segments, drain
  initial begin : stimulus
    int unsigned   sent;
    int unsigned   seg_len;
    int unsigned   pick_pct;
    int unsigned   fill_lvl;
    int unsigned   fill_len;
    bit            fill_done;
    sched_result_t typed_res;
    run_failed          = 1'b0;
    burst_left          = 0;
    sent                = 0;
    fill_done           = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.func         = FUNC_ENQUEUE;
    req_ch.task_slot    = '0;
    req_ch.priority_req = '0;
    for (int l = 0; l < LEVELS; l++) begin
      lvl_head[l]   = 0;
      lvl_tail[l]   = 0;
      lvl_fill[l]   = 0;
      lvl_served[l] = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      typed_res.slot   = directed_rows[i].exp_slot;
      typed_res.status = directed_rows[i].exp_status;
      send_request(directed_rows[i].func, directed_rows[i].slot, directed_rows[i].prio,
                   directed_rows[i].typed, typed_res);
    end

    while (sent < RANDOM_ITEMS) begin
      if (!fill_done && sent >= 100) begin
        // fill one level to the brim, knock on it a few more times, then
        // pick everything out again so that both indexes wrap
        fill_lvl = $urandom_range(0, LEVELS - 1);
        fill_len = TASK_SLOTS - lvl_fill[fill_lvl] + $urandom_range(2, 4);
        for (int n = 0; n < fill_len; n++) begin
          send_request(FUNC_ENQUEUE, SLOT_W'($urandom_range(0, 255)),
                       PRIO_W'(fill_lvl), 1'b0, '0);
        end
        sent += fill_len;
        while (lvl_fill[fill_lvl] != 0) begin
          send_random_pick();
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          send_random_pick();
          sent++;
        end
        fill_done = 1'b1;
      end else begin
        // mixed traffic; the pick share decides whether queues grow or shrink
        seg_len  = $urandom_range(10, 60);
        pick_pct = 25 * $urandom_range(1, 3);
        for (int n = 0; n < seg_len; n++) begin
          if ($urandom_range(0, 99) < pick_pct) begin
            send_random_pick();
          end else begin
            send_random_enqueue();
          end
        end
        sent += seg_len;
      end
    end
    req_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    // keep running after the drain to catch anything the block still pushes out
    repeat (10) @(posedge clk_i);
    if (!run_failed) begin
      $display("multilevel_ready_queue_scheduler_core_test passed");
    end else begin
      $display("multilevel_ready_queue_scheduler_core_test failed");
    end
    $finish;
  end

  // result side: a changing stall pattern, plus two long hold-offs that
  // back the pipeline up into the request channel
  initial begin : result_sink
    int unsigned cyc;
    int unsigned taken;
    int unsigned hold_left;
    cyc          = 0;
    taken        = 0;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (res_ch.valid && res_ch.ready) begin
        taken++;
        if (taken == 40 || taken == 450) hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case ((cyc / 50) % 4)
          0: begin
            res_ch.ready <= 1'b1;
          end
          1: begin
            res_ch.ready <= ($urandom_range(0, 1) == 1);
          end
          2: begin
            res_ch.ready <= (cyc % 3 == 0);
          end
          default: begin
            res_ch.ready <= ($urandom_range(0, 4) != 0);
          end
        endcase
      end
    end
  end

  // compare every taken result with the oldest expectation
  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing outstanding: picked_slot %0h status %0d",
               res_ch.picked_slot, res_ch.status);
        run_failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (res_ch.picked_slot !== want.slot) begin
          $error("picked_slot: expected %0h, got %0h", want.slot, res_ch.picked_slot);
          run_failed = 1'b1;
        end
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          run_failed = 1'b1;
        end
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("multilevel_ready_queue_scheduler_core_test failed");
    $finish;
  end

endmodule
